// ----- src/dual_wheel_pid_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// dual wheel pid controller assertion macros
// shared assertion shorthands, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_CONTROLLER_UNIT_MACROS_SVH
`define DUAL_WHEEL_PID_CONTROLLER_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define DWPID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the following cycle
`define DWPID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dwpid_pkg.sv -----
// ----------------------------------------------------------------------------
// dwpid package
// shared widths, reset values, register codes and types of the pid unit
// ----------------------------------------------------------------------------
package dwpid_pkg;

    localparam int COUNT_W = 16;
    localparam int GAIN_W  = 20;
    localparam int DUTY_W  = 10;
    localparam int ERR_W   = 18;
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;

    localparam int DEF_GAIN_FRAC_BITS   = 12;
    localparam int DEF_INTEGRATOR_WIDTH = 48;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_REF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_KP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_KI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_KD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIM  = 3'd7;

    // reset values
    localparam logic [COUNT_W-1:0] RST_SPEED_REF = 16'd30;
    localparam logic [GAIN_W-1:0]  RST_SPEED_KP  = 20'd294912;
    localparam logic [GAIN_W-1:0]  RST_SPEED_KI  = 20'd2458;
    localparam logic [GAIN_W-1:0]  RST_SPEED_KD  = 20'd614;
    localparam logic [GAIN_W-1:0]  RST_SYNC_KP   = 20'd40960;
    localparam logic [GAIN_W-1:0]  RST_SYNC_KI   = 20'd819;
    localparam logic [GAIN_W-1:0]  RST_SYNC_KD   = 20'd61;
    localparam logic [DUTY_W-1:0]  RST_DUTY_LIM  = 10'd1000;

    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
        logic               restart;
    } t_in_word;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gain_set;

    typedef struct packed {
        t_prod kpe;
        t_prod kie;
        t_prod kdd;
    } t_loop_terms;

    typedef struct packed {
        logic [COUNT_W-1:0] inc;
        t_loop_terms        speed;
        t_loop_terms        sync;
        logic               restart;
    } t_err_terms;

    // unsigned gain times signed error
    function automatic t_prod mul_gain(logic [GAIN_W-1:0] k, t_err v);
        t_prod a;
        t_prod b;
        a = signed'({{(PROD_W-GAIN_W){1'b0}}, k});
        b = PROD_W'(v);
        return a * b;
    endfunction

endpackage

// ----- src/dwpid_stream_if.sv -----
// ----------------------------------------------------------------------------
// dwpid stream interfaces
// valid/ready channels for encoder ticks and duty results
// ----------------------------------------------------------------------------
interface dwpid_in_if;
    logic                            valid;
    logic                            ready;
    logic [dwpid_pkg::COUNT_W-1:0]   left_count;
    logic [dwpid_pkg::COUNT_W-1:0]   right_count;
    logic                            restart;

    modport source (output valid, output left_count, output right_count, output restart,
                    input ready);
    modport sink   (input valid, input left_count, input right_count, input restart,
                    output ready);
endinterface

interface dwpid_out_if;
    logic                            valid;
    logic                            ready;
    logic [dwpid_pkg::DUTY_W-1:0]    left_duty;
    logic [dwpid_pkg::DUTY_W-1:0]    right_duty;
    logic [dwpid_pkg::COUNT_W-1:0]   left_increment;

    modport source (output valid, output left_duty, output right_duty,
                    output left_increment, input ready);
    modport sink   (input valid, input left_duty, input right_duty,
                    input left_increment, output ready);
endinterface

// ----- src/dwpid_err_mul.sv -----
// ----------------------------------------------------------------------------
// dwpid error and product stage
// forms speed and sync errors, their deltas, and the gain products
// ----------------------------------------------------------------------------
module dwpid_err_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  dwpid_pkg::t_in_word           i_word,
    input  logic [dwpid_pkg::COUNT_W-1:0] i_speed_ref,
    input  dwpid_pkg::t_gain_set          i_speed_gains,
    input  dwpid_pkg::t_gain_set          i_sync_gains,
    output dwpid_pkg::t_err_terms         o_terms
);

    logic [dwpid_pkg::COUNT_W-1:0] r_prev_left;
    dwpid_pkg::t_err               r_speed_prev;
    dwpid_pkg::t_err               r_sync_prev;
    dwpid_pkg::t_err_terms         r_terms;

    logic [dwpid_pkg::COUNT_W-1:0] w_prev_left;
    logic [dwpid_pkg::COUNT_W-1:0] w_inc;
    dwpid_pkg::t_err               w_speed_err;
    dwpid_pkg::t_err               w_sync_err;
    dwpid_pkg::t_err               w_speed_de;
    dwpid_pkg::t_err               w_sync_de;
    dwpid_pkg::t_err_terms         n_terms;

    always_comb begin
        w_prev_left = i_word.restart ? '0 : r_prev_left;
        w_inc       = i_word.left_count - w_prev_left;
        w_speed_err = signed'(dwpid_pkg::ERR_W'(i_speed_ref)) -
                      signed'(dwpid_pkg::ERR_W'(w_inc));
        w_sync_err  = signed'(dwpid_pkg::ERR_W'(i_word.left_count)) -
                      signed'(dwpid_pkg::ERR_W'(i_word.right_count));
        // previous errors read as zero on restart
        w_speed_de  = w_speed_err - (i_word.restart ? '0 : r_speed_prev);
        w_sync_de   = w_sync_err - (i_word.restart ? '0 : r_sync_prev);

        n_terms.inc       = w_inc;
        n_terms.restart   = i_word.restart;
        n_terms.speed.kpe = dwpid_pkg::mul_gain(i_speed_gains.kp, w_speed_err);
        n_terms.speed.kie = dwpid_pkg::mul_gain(i_speed_gains.ki, w_speed_err);
        n_terms.speed.kdd = dwpid_pkg::mul_gain(i_speed_gains.kd, w_speed_de);
        n_terms.sync.kpe  = dwpid_pkg::mul_gain(i_sync_gains.kp, w_sync_err);
        n_terms.sync.kie  = dwpid_pkg::mul_gain(i_sync_gains.ki, w_sync_err);
        n_terms.sync.kdd  = dwpid_pkg::mul_gain(i_sync_gains.kd, w_sync_de);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_speed_prev <= '0;
            r_sync_prev  <= '0;
        end else if (i_en) begin
            r_prev_left  <= i_word.left_count;
            r_speed_prev <= w_speed_err;
            r_sync_prev  <= w_sync_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ----- src/dwpid_integ.sv -----
// ----------------------------------------------------------------------------
// dwpid integrator stage
// saturating integrators and the pid sums of both loops
// ----------------------------------------------------------------------------
module dwpid_integ #(
    parameter int INTEGRATOR_WIDTH = dwpid_pkg::DEF_INTEGRATOR_WIDTH,
    parameter int OUT_W            = dwpid_pkg::DEF_INTEGRATOR_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  dwpid_pkg::t_err_terms         i_terms,
    output logic signed [OUT_W-1:0]       o_u_speed,
    output logic signed [OUT_W-1:0]       o_u_sync,
    output logic [dwpid_pkg::COUNT_W-1:0] o_inc
);

    localparam int IW = INTEGRATOR_WIDTH;
    localparam int SW = ((IW > dwpid_pkg::PROD_W) ? IW : dwpid_pkg::PROD_W) + 1;
    localparam logic signed [SW-1:0] IHI = (SW'(1) <<< (IW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] ILO = -IHI - SW'(1);

    logic signed [IW-1:0]          r_speed_i;
    logic signed [IW-1:0]          r_sync_i;
    logic signed [OUT_W-1:0]       r_u_speed;
    logic signed [OUT_W-1:0]       r_u_sync;
    logic [dwpid_pkg::COUNT_W-1:0] r_inc;

    logic signed [SW-1:0]          w_speed_sum;
    logic signed [SW-1:0]          w_sync_sum;
    logic signed [IW-1:0]          n_speed_i;
    logic signed [IW-1:0]          n_sync_i;
    logic signed [OUT_W-1:0]       n_u_speed;
    logic signed [OUT_W-1:0]       n_u_sync;

    always_comb begin
        // integrators sign-extended, zero on restart
        w_speed_sum = (i_terms.restart ? SW'(0) : SW'(r_speed_i)) +
                      SW'(signed'(i_terms.speed.kie));
        w_sync_sum  = (i_terms.restart ? SW'(0) : SW'(r_sync_i)) +
                      SW'(signed'(i_terms.sync.kie));

        if (w_speed_sum > IHI) begin
            n_speed_i = IW'(IHI);
        end else if (w_speed_sum < ILO) begin
            n_speed_i = IW'(ILO);
        end else begin
            n_speed_i = IW'(w_speed_sum);
        end

        if (w_sync_sum > IHI) begin
            n_sync_i = IW'(IHI);
        end else if (w_sync_sum < ILO) begin
            n_sync_i = IW'(ILO);
        end else begin
            n_sync_i = IW'(w_sync_sum);
        end

        n_u_speed = OUT_W'(n_speed_i) + OUT_W'(signed'(i_terms.speed.kpe)) +
                    OUT_W'(signed'(i_terms.speed.kdd));
        n_u_sync  = OUT_W'(n_sync_i) + OUT_W'(signed'(i_terms.sync.kpe)) +
                    OUT_W'(signed'(i_terms.sync.kdd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_i <= '0;
            r_sync_i  <= '0;
        end else if (i_en) begin
            r_speed_i <= n_speed_i;
            r_sync_i  <= n_sync_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_speed <= n_u_speed;
            r_u_sync  <= n_u_sync;
            r_inc     <= i_terms.inc;
        end
    end

    assign o_u_speed = r_u_speed;
    assign o_u_sync  = r_u_sync;
    assign o_inc     = r_inc;

endmodule

// ----- src/dwpid_duty.sv -----
// ----------------------------------------------------------------------------
// dwpid duty stage
// clamps both loop outputs to the duty range and holds the result word
// ----------------------------------------------------------------------------
module dwpid_duty #(
    parameter int GAIN_FRAC_BITS = dwpid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int OUT_W          = dwpid_pkg::DEF_INTEGRATOR_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [OUT_W-1:0]       i_u_speed,
    input  logic signed [OUT_W-1:0]       i_u_sync,
    input  logic [dwpid_pkg::COUNT_W-1:0] i_inc,
    input  logic [dwpid_pkg::DUTY_W-1:0]  i_duty_limit,
    output logic [dwpid_pkg::DUTY_W-1:0]  o_left_duty,
    output logic [dwpid_pkg::DUTY_W-1:0]  o_right_duty,
    output logic [dwpid_pkg::COUNT_W-1:0] o_inc
);

    logic [dwpid_pkg::DUTY_W-1:0]  r_left_duty;
    logic [dwpid_pkg::DUTY_W-1:0]  r_right_duty;
    logic [dwpid_pkg::COUNT_W-1:0] r_inc;

    logic signed [OUT_W-1:0]       w_top;
    logic signed [OUT_W-1:0]       w_l_fix;
    logic signed [OUT_W:0]         w_r_sum;
    logic signed [OUT_W:0]         w_r_fix;

    always_comb begin
        w_top = signed'(OUT_W'(i_duty_limit) << GAIN_FRAC_BITS);

        if (i_u_speed[OUT_W-1]) begin
            w_l_fix = '0;
        end else if (i_u_speed > w_top) begin
            w_l_fix = w_top;
        end else begin
            w_l_fix = i_u_speed;
        end

        // right side adds sync on top of the clamped speed term
        w_r_sum = (OUT_W+1)'(w_l_fix) + (OUT_W+1)'(i_u_sync);
        if (w_r_sum[OUT_W]) begin
            w_r_fix = '0;
        end else if (w_r_sum > (OUT_W+1)'(w_top)) begin
            w_r_fix = (OUT_W+1)'(w_top);
        end else begin
            w_r_fix = w_r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left_duty  <= dwpid_pkg::DUTY_W'(w_l_fix >>> GAIN_FRAC_BITS);
            r_right_duty <= dwpid_pkg::DUTY_W'(w_r_fix >>> GAIN_FRAC_BITS);
            r_inc        <= i_inc;
        end
    end

    assign o_left_duty  = r_left_duty;
    assign o_right_duty = r_right_duty;
    assign o_inc        = r_inc;

endmodule

// ----- src/dual_wheel_pid_controller_unit.sv -----
// ----------------------------------------------------------------------------
// dual wheel pid controller unit
// speed pid on the left wheel increment plus a sync pid on left minus right
// ----------------------------------------------------------------------------
//
//  port   | dir | word                                   | handshake
//  -------+-----+----------------------------------------+-------------
//  i_in   | in  | left_count, right_count, restart       | valid/ready
//  o_out  | out | left_duty, right_duty, left_increment  | valid/ready
//  i_cfg  | in  | i_cfg_index, i_cfg_data                | i_cfg_we only
//
//  four register stages: input word, error/products, integrators/sums,
//  clamped result; an accepted word passes through them in order to o_out
//  one word a cycle sustained while o_out accepts every word
//  i_rst_n is synchronous: clears valids, loop state, config to defaults
//  a stalled o_out holds its word; stages fill behind it and i_in.ready
//  drops only once all four stages hold a word
//
`include "dual_wheel_pid_controller_unit_macros.svh"

module dual_wheel_pid_controller_unit #(
    parameter int GAIN_FRAC_BITS   = dwpid_pkg::DEF_GAIN_FRAC_BITS,
    parameter int INTEGRATOR_WIDTH = dwpid_pkg::DEF_INTEGRATOR_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dwpid_in_if.sink                         i_in,
    dwpid_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [dwpid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dwpid_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // loop output width: integrator plus two product terms
    localparam int OUT_W = ((INTEGRATOR_WIDTH > dwpid_pkg::PROD_W) ?
                            INTEGRATOR_WIDTH : dwpid_pkg::PROD_W) + 2;

    // configuration registers
    logic [dwpid_pkg::COUNT_W-1:0] r_speed_ref;
    dwpid_pkg::t_gain_set          r_speed_gains;
    dwpid_pkg::t_gain_set          r_sync_gains;
    logic [dwpid_pkg::DUTY_W-1:0]  r_duty_limit;

    // stage valids
    logic r_v0;
    logic r_v1;
    logic r_v2;
    logic r_vo;

    // stage advance enables, computed from the output side back
    logic w_en0;
    logic w_en1;
    logic w_en2;
    logic w_en_o;

    dwpid_pkg::t_in_word           r_word;
    dwpid_pkg::t_in_word           w_word;
    dwpid_pkg::t_err_terms         w_terms;
    logic signed [OUT_W-1:0]       w_u_speed;
    logic signed [OUT_W-1:0]       w_u_sync;
    logic [dwpid_pkg::COUNT_W-1:0] w_inc_b;
    logic [dwpid_pkg::DUTY_W-1:0]  w_left_duty;
    logic [dwpid_pkg::DUTY_W-1:0]  w_right_duty;
    logic [dwpid_pkg::COUNT_W-1:0] w_inc_o;

    // config writes; excess data bits dropped, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_ref      <= dwpid_pkg::RST_SPEED_REF;
            r_speed_gains.kp <= dwpid_pkg::RST_SPEED_KP;
            r_speed_gains.ki <= dwpid_pkg::RST_SPEED_KI;
            r_speed_gains.kd <= dwpid_pkg::RST_SPEED_KD;
            r_sync_gains.kp  <= dwpid_pkg::RST_SYNC_KP;
            r_sync_gains.ki  <= dwpid_pkg::RST_SYNC_KI;
            r_sync_gains.kd  <= dwpid_pkg::RST_SYNC_KD;
            r_duty_limit     <= dwpid_pkg::RST_DUTY_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dwpid_pkg::CFG_SPEED_REF: r_speed_ref <= i_cfg_data[dwpid_pkg::COUNT_W-1:0];
                dwpid_pkg::CFG_SPEED_KP:  r_speed_gains.kp <= i_cfg_data;
                dwpid_pkg::CFG_SPEED_KI:  r_speed_gains.ki <= i_cfg_data;
                dwpid_pkg::CFG_SPEED_KD:  r_speed_gains.kd <= i_cfg_data;
                dwpid_pkg::CFG_SYNC_KP:   r_sync_gains.kp <= i_cfg_data;
                dwpid_pkg::CFG_SYNC_KI:   r_sync_gains.ki <= i_cfg_data;
                dwpid_pkg::CFG_SYNC_KD:   r_sync_gains.kd <= i_cfg_data;
                dwpid_pkg::CFG_DUTY_LIM:  r_duty_limit <= i_cfg_data[dwpid_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage may load when it is empty or its word moves on this cycle
    assign w_en_o = !r_vo || o_out.ready;
    assign w_en2  = !r_v2 || w_en_o;
    assign w_en1  = !r_v1 || w_en2;
    assign w_en0  = !r_v0 || w_en1;

    assign i_in.ready = w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= i_in.valid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // input word register
    always_comb begin
        w_word.left_count  = i_in.left_count;
        w_word.right_count = i_in.right_count;
        w_word.restart     = i_in.restart;
    end

    always_ff @(posedge i_clk) begin
        if (w_en0 && i_in.valid) begin
            r_word <= w_word;
        end
    end

    // errors and gain products; previous count and errors live here
    dwpid_err_mul u_err_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (r_v0 && w_en1),
        .i_word        (r_word),
        .i_speed_ref   (r_speed_ref),
        .i_speed_gains (r_speed_gains),
        .i_sync_gains  (r_sync_gains),
        .o_terms       (w_terms)
    );

    // integrators and pid sums
    dwpid_integ #(
        .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH),
        .OUT_W            (OUT_W)
    ) u_integ (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (r_v1 && w_en2),
        .i_terms   (w_terms),
        .o_u_speed (w_u_speed),
        .o_u_sync  (w_u_sync),
        .o_inc     (w_inc_b)
    );

    // clamp and output register
    dwpid_duty #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .OUT_W          (OUT_W)
    ) u_duty (
        .i_clk        (i_clk),
        .i_en         (r_v2 && w_en_o),
        .i_u_speed    (w_u_speed),
        .i_u_sync     (w_u_sync),
        .i_inc        (w_inc_b),
        .i_duty_limit (r_duty_limit),
        .o_left_duty  (w_left_duty),
        .o_right_duty (w_right_duty),
        .o_inc        (w_inc_o)
    );

    assign o_out.valid          = r_vo;
    assign o_out.left_duty      = w_left_duty;
    assign o_out.right_duty     = w_right_duty;
    assign o_out.left_increment = w_inc_o;

    // an accepted word always lands in the input stage
    `DWPID_ASSERT_NEXT(a_accept_lands, i_in.valid && i_in.ready, r_v0, "accepted word lost")
    // an empty input stage never refuses a word
    `DWPID_ASSERT_SAME(a_empty_ready, !r_v0, i_in.ready, "ready low with empty input stage")
    // a full pipe with a stalled output must refuse input
    `DWPID_ASSERT_SAME(a_full_stall, r_v0 && r_v1 && r_v2 && r_vo && !o_out.ready,
                       !i_in.ready, "input taken while pipe full and stalled")
    // a word moving out of the last stage shows up on the output
    `DWPID_ASSERT_NEXT(a_last_to_out, r_v2 && w_en_o, o_out.valid, "result not presented")

endmodule

// ----- bench/dual_wheel_pid_controller_unit_tb.sv -----
// ----------------------------------------------------------------------------
// dual wheel pid controller unit testbench
// drives encoder tick words through the unit with random idle and stall
// gaps, predicts every duty word with a fixed-point model of both pid loops,
// and compares each result word field by field in arrival order
// ----------------------------------------------------------------------------
module dual_wheel_pid_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwpid_pkg::*;

    localparam int GAIN_FRAC = DEF_GAIN_FRAC_BITS;
    // signed integrator range of the unit's default width
    localparam longint INTEG_MAX = (longint'(1) <<< (DEF_INTEGRATOR_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;

    // one result word as it leaves o_out
    typedef struct packed {
        logic [DUTY_W-1:0]  left_duty;
        logic [DUTY_W-1:0]  right_duty;
        logic [COUNT_W-1:0] left_increment;
    } t_duty_word;

    // full register set of the unit
    typedef struct packed {
        logic [COUNT_W-1:0] speed_ref;
        t_gain_set          speed_gains;
        t_gain_set          sync_gains;
        logic [DUTY_W-1:0]  duty_lim;
    } t_pid_cfg;

    // integrator and last error of one pid loop
    typedef struct packed {
        longint acc;
        int     last_err;
    } t_loop;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dwpid_in_if  tick_if ();
    dwpid_out_if duty_if ();

    dual_wheel_pid_controller_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (duty_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // controller model: registers and loop state
    t_pid_cfg           cfg;
    t_loop              speed_loop;
    t_loop              sync_loop;
    logic [COUNT_W-1:0] last_left;

    t_in_word   tick_q[$];  // tick words not yet sent
    t_duty_word duty_q[$];  // predicted duty words, oldest first
    int         ticks_outstanding;
    int         err_count;

    // idle shaping on both sides, percent chance per cycle of starting a gap
    int send_idle_pct;
    int stall_pct;
    int send_gap;
    int stall_left;
    bit tick_taken;

    // wheel positions for well-formed encoder sequences
    logic [COUNT_W-1:0] wheel_left;
    logic [COUNT_W-1:0] wheel_skew;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // integrator update with saturation, then p, i and d summed; 64 bits
    // hold every sum here, since gains and errors are narrow
    function automatic longint loop_step(inout t_loop st, input int err,
                                         input t_gain_set g);
        longint e;
        longint u;
        e = err;
        st.acc = st.acc + longint'(g.ki) * e;
        if (st.acc > INTEG_MAX) begin
            st.acc = INTEG_MAX;
        end else if (st.acc < INTEG_MIN) begin
            st.acc = INTEG_MIN;
        end
        u = st.acc + longint'(g.kp) * e + longint'(g.kd) * (e - longint'(st.last_err));
        st.last_err = err;
        return u;
    endfunction

    function automatic longint clamp_fix(input longint v, input longint top);
        if (v > top) begin
            return top;
        end else if (v < 0) begin
            return 0;
        end
        return v;
    endfunction

    // one control tick of the model: returns the duty word it produces
    function automatic t_duty_word advance_controller(input t_in_word w);
        logic [COUNT_W-1:0] inc;
        int         speed_err;
        int         sync_err;
        longint     u_speed;
        longint     u_sync;
        longint     top;
        longint     l_fix;
        longint     r_fix;
        t_duty_word r;
        if (w.restart) begin
            speed_loop = '0;
            sync_loop  = '0;
            last_left  = '0;
        end
        inc       = w.left_count - last_left;
        last_left = w.left_count;
        speed_err = int'(cfg.speed_ref) - int'(inc);
        sync_err  = int'(w.left_count) - int'(w.right_count);
        u_speed   = loop_step(speed_loop, speed_err, cfg.speed_gains);
        u_sync    = loop_step(sync_loop, sync_err, cfg.sync_gains);
        top       = longint'(cfg.duty_lim) <<< GAIN_FRAC;
        l_fix     = clamp_fix(u_speed, top);
        r_fix     = clamp_fix(l_fix + u_sync, top);
        r.left_duty      = DUTY_W'(l_fix >>> GAIN_FRAC);
        r.right_duty     = DUTY_W'(r_fix >>> GAIN_FRAC);
        r.left_increment = inc;
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        return GAIN_W'($urandom) >> $urandom_range(0, GAIN_W - 1);
    endfunction

    function automatic t_pid_cfg random_cfg();
        t_pid_cfg c;
        c.speed_ref      = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom)
                                                       : COUNT_W'($urandom_range(0, 400));
        c.speed_gains.kp = rand_gain();
        c.speed_gains.ki = rand_gain();
        c.speed_gains.kd = rand_gain();
        c.sync_gains.kp  = rand_gain();
        c.sync_gains.ki  = rand_gain();
        c.sync_gains.kd  = rand_gain();
        c.duty_lim       = DUTY_W'($urandom);
        return c;
    endfunction

    // register write, only called while the unit is idle
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            CFG_SPEED_REF: cfg.speed_ref      = data[COUNT_W-1:0];
            CFG_SPEED_KP:  cfg.speed_gains.kp = data;
            CFG_SPEED_KI:  cfg.speed_gains.ki = data;
            CFG_SPEED_KD:  cfg.speed_gains.kd = data;
            CFG_SYNC_KP:   cfg.sync_gains.kp  = data;
            CFG_SYNC_KI:   cfg.sync_gains.ki  = data;
            CFG_SYNC_KD:   cfg.sync_gains.kd  = data;
            CFG_DUTY_LIM:  cfg.duty_lim       = data[DUTY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // all eight registers; bits above the narrow registers carry junk
    task automatic load_cfg(input t_pid_cfg c);
        reg_write(CFG_SPEED_REF, {4'($urandom), c.speed_ref});
        reg_write(CFG_SPEED_KP, c.speed_gains.kp);
        reg_write(CFG_SPEED_KI, c.speed_gains.ki);
        reg_write(CFG_SPEED_KD, c.speed_gains.kd);
        reg_write(CFG_SYNC_KP, c.sync_gains.kp);
        reg_write(CFG_SYNC_KI, c.sync_gains.ki);
        reg_write(CFG_SYNC_KD, c.sync_gains.kd);
        reg_write(CFG_DUTY_LIM, {10'($urandom), c.duty_lim});
    endtask

    task automatic queue_one(input logic [COUNT_W-1:0] left, input logic [COUNT_W-1:0] right,
                             input logic restart);
        t_in_word w;
        w.left_count  = left;
        w.right_count = right;
        w.restart     = restart;
        tick_q.push_back(w);
        ticks_outstanding++;
    endtask

    // mostly cruising wheels near the speed target with a slow skew
    // between them, the rest random counts and restarts
    task automatic queue_ticks(input int count, input int noise_pct);
        int k;
        int step;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                queue_one(COUNT_W'($urandom), COUNT_W'($urandom),
                          $urandom_range(0, 7) == 0);
            end else begin
                step = int'(cfg.speed_ref) + int'($urandom_range(0, 8)) - 4;
                if ($urandom_range(0, 19) == 0) begin
                    step = step + int'($urandom_range(0, 200)) - 100;
                end
                if ($urandom_range(0, 9) == 0) begin
                    wheel_skew = wheel_skew + COUNT_W'(int'($urandom_range(0, 20)) - 10);
                end
                wheel_left = wheel_left + COUNT_W'(step);
                queue_one(wheel_left, wheel_left + wheel_skew, $urandom_range(0, 49) == 0);
            end
        end
    endtask

    // block until every queued word has come back
    task automatic wait_idle();
        while (ticks_outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // tick driver: posedge records acceptance and predicts, negedge drives
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tick_accept
        t_in_word w;
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            w.left_count  = tick_if.left_count;
            w.right_count = tick_if.right_count;
            w.restart     = tick_if.restart;
            duty_q.push_back(advance_controller(w));
            tick_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : tick_drive
        t_in_word w;
        if (i_rst_n) begin
            if (tick_if.valid && !tick_taken) begin
                // word still waiting on ready, hold it
            end else if (send_gap > 0) begin
                tick_if.valid <= 1'b0;
                send_gap--;
            end else if (tick_q.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                tick_if.valid <= 1'b0;
                send_gap = gap_len() - 1;
            end else if (tick_q.size() != 0) begin
                w = tick_q.pop_front();
                tick_if.valid       <= 1'b1;
                tick_if.left_count  <= w.left_count;
                tick_if.right_count <= w.right_count;
                tick_if.restart     <= w.restart;
            end else begin
                tick_if.valid <= 1'b0;
            end
            tick_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // duty monitor: random backpressure, in-order field compare
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : duty_ready
        if (!i_rst_n) begin
            duty_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            duty_if.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            duty_if.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            duty_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : duty_check
        t_duty_word want;
        if (i_rst_n && duty_if.valid && duty_if.ready) begin
            if (duty_q.size() == 0) begin
                $display("%0t ns: unexpected duty word, expected none, got %0d/%0d/%0d",
                         $time, duty_if.left_duty, duty_if.right_duty,
                         duty_if.left_increment);
                err_count++;
            end else begin
                want = duty_q.pop_front();
                if (duty_if.left_duty !== want.left_duty) begin
                    $display("%0t ns: left_duty mismatch, expected %0d, got %0d",
                             $time, want.left_duty, duty_if.left_duty);
                    err_count++;
                end
                if (duty_if.right_duty !== want.right_duty) begin
                    $display("%0t ns: right_duty mismatch, expected %0d, got %0d",
                             $time, want.right_duty, duty_if.right_duty);
                    err_count++;
                end
                if (duty_if.left_increment !== want.left_increment) begin
                    $display("%0t ns: left_increment mismatch, expected %0d, got %0d",
                             $time, want.left_increment, duty_if.left_increment);
                    err_count++;
                end
                ticks_outstanding--;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        t_pid_cfg c;
        int       k;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_SPEED_REF;
        i_cfg_data          = '0;
        tick_if.valid       = 1'b0;
        tick_if.left_count  = '0;
        tick_if.right_count = '0;
        tick_if.restart     = 1'b0;
        duty_if.ready       = 1'b0;
        cfg.speed_ref       = RST_SPEED_REF;
        cfg.speed_gains     = {RST_SPEED_KP, RST_SPEED_KI, RST_SPEED_KD};
        cfg.sync_gains      = {RST_SYNC_KP, RST_SYNC_KI, RST_SYNC_KD};
        cfg.duty_lim        = RST_DUTY_LIM;
        speed_loop          = '0;
        sync_loop           = '0;
        last_left           = '0;
        wheel_left          = '0;
        wheel_skew          = '0;
        ticks_outstanding   = 0;
        err_count           = 0;
        send_gap            = 0;
        stall_left          = 0;
        tick_taken          = 1'b0;
        send_idle_pct       = 20;
        stall_pct           = 20;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed ticks on the reset defaults
        queue_one(16'd0, 16'd0, 1'b1);          // restart from zero counts
        queue_one(16'd30, 16'd30, 1'b0);        // on target, wheels level
        queue_one(16'd60, 16'd59, 1'b0);
        queue_one(16'd65535, 16'd0, 1'b0);      // huge increment, speed duty to zero
        queue_one(16'd65535, 16'd65535, 1'b0);  // wheel stopped, right duty at limit, left at zero
        queue_one(16'd5, 16'd0, 1'b0);          // increment wraps past zero
        queue_one(16'd0, 16'd65535, 1'b0);      // most negative sync error
        queue_one(16'd100, 16'd100, 1'b1);      // restart with overshoot, negative output
        queue_one(16'd100, 16'd100, 1'b0);      // stalled wheel, output above the limit
        queue_one(16'd130, 16'd100, 1'b0);
        queue_one(16'd65535, 16'd65535, 1'b1);
        queue_one(16'd65534, 16'd1, 1'b0);      // increment of all ones
        queue_one(16'd28, 16'd30, 1'b0);
        queue_one(16'd58, 16'd61, 1'b0);
        queue_one(16'd88, 16'd90, 1'b0);
        queue_one(16'd118, 16'd118, 1'b0);
        queue_one(16'd148, 16'd150, 1'b1);
        queue_one(16'd178, 16'd177, 1'b0);
        wait_idle();

        // defaults again, cruising, no idling on either side
        send_idle_pct = 0;
        stall_pct     = 0;
        wheel_left    = 16'd178;
        queue_ticks(250, 5);
        wait_idle();

        // random gains
        send_idle_pct = 25;
        stall_pct     = 25;
        load_cfg(random_cfg());
        queue_ticks(250, 30);
        wait_idle();

        // every register at zero: both duties pinned to zero
        load_cfg('0);
        queue_ticks(30, 100);
        wait_idle();

        // everything at maximum: stopped left wheel, right wheel far behind,
        // both integrators climb steeply
        send_idle_pct = 5;
        stall_pct     = 5;
        load_cfg('1);
        queue_one(16'd65535, 16'd0, 1'b1);
        for (k = 0; k < 150; k++) begin
            queue_one(16'd65535, 16'd0, 1'b0);
        end
        wait_idle();

        // integral only, opposite errors: both integrators wind back down
        // through zero and the duties fall to zero
        c = '0;
        c.speed_gains.ki = '1;
        c.sync_gains.ki  = '1;
        c.duty_lim       = '1;
        load_cfg(c);
        for (k = 0; k < 200; k++) begin
            queue_one(COUNT_W'(4700 - k), 16'd65535, 1'b0);
        end
        wait_idle();

        // random settings, mostly cruising, last one under heavy idling
        send_idle_pct = 15;
        stall_pct     = 15;
        for (k = 0; k < 3; k++) begin
            if (k == 2) begin
                send_idle_pct = 60;
                stall_pct     = 60;
            end
            load_cfg(random_cfg());
            queue_ticks(120, 20);
            wait_idle();
        end

        // drain, then watch for stray words
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && duty_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard: several times the slowest legal run
    initial begin
        #(60_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/dwpid_pkg.sv
src/dwpid_stream_if.sv
src/dwpid_err_mul.sv
src/dwpid_integ.sv
src/dwpid_duty.sv
src/dual_wheel_pid_controller_unit.sv
bench/dual_wheel_pid_controller_unit_tb.sv
